// ----- hw/rtl/hnbs_pkg.sv -----
// ----------------------------------------------------------------------------
// hnbs_pkg
// Shared types and constants for the HDLC NRZI bit-stuffing serializer.
// ----------------------------------------------------------------------------
package hnbs_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned BitIdxW = $clog2(ByteW);
  localparam int unsigned RunW    = 3;

  // consecutive ones that trigger a stuffing zero
  localparam logic [RunW-1:0]    StuffRun = RunW'(5);
  localparam logic [BitIdxW-1:0] LastBit  = BitIdxW'(ByteW - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DATA,
    ST_STUFF
  } state_e;

  typedef struct packed {
    logic load;
    logic data_take;
    logic stuff_take;
    logic in_stuff;
  } cmd_t;

  typedef struct packed {
    logic stuff_req;
    logic last_bit;
    logic stuff_last;
  } status_t;

endpackage

// ----- hw/rtl/hnbs_dp.sv -----
// ----------------------------------------------------------------------------
// hnbs_dp
// Datapath: byte shifter, bit index, NRZI tone and ones-run counter.
// ----------------------------------------------------------------------------
module hnbs_dp import hnbs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  input  logic [ByteW-1:0] byte_in_i,
  input  logic             is_flag_i,
  output status_t          status_o,
  output logic             tone_sel_o,
  output logic             stuffed_o,
  output logic             last_o
);

  logic [ByteW-1:0]   shift_q, shift_d;
  logic [BitIdxW-1:0] idx_q, idx_d;
  logic               flag_q, flag_d;
  logic               tone_q, tone_d;
  logic [RunW-1:0]    ones_q, ones_d;
  logic [RunW-1:0]    ones_inc;
  logic               cur_bit;
  logic               stuff_req;
  logic               last_bit;
  logic               stuff_last;

  assign cur_bit    = shift_q[0];
  assign ones_inc   = ones_q + RunW'(1);
  assign stuff_req  = cur_bit & ~flag_q & (ones_inc >= StuffRun);
  assign last_bit   = (idx_q == LastBit);
  // index wraps to zero once the eighth bit is taken
  assign stuff_last = (idx_q == '0);

  assign status_o.stuff_req  = stuff_req;
  assign status_o.last_bit   = last_bit;
  assign status_o.stuff_last = stuff_last;

  assign tone_sel_o = cmd_i.in_stuff ? ~tone_q : (cur_bit ? tone_q : ~tone_q);
  assign stuffed_o  = cmd_i.in_stuff;
  assign last_o     = cmd_i.in_stuff ? stuff_last : (last_bit & ~stuff_req);

  always_comb begin
    shift_d = shift_q;
    idx_d   = idx_q;
    flag_d  = flag_q;
    tone_d  = tone_q;
    ones_d  = ones_q;
    if (cmd_i.load) begin
      shift_d = byte_in_i;
      idx_d   = '0;
      flag_d  = is_flag_i;
    end else if (cmd_i.data_take) begin
      if (cur_bit) begin
        if (!flag_q) begin
          ones_d = ones_inc;
        end
      end else begin
        tone_d = ~tone_q;
        ones_d = '0;
      end
      if (last_bit && flag_q) begin
        ones_d = '0;
      end
      shift_d = shift_q >> 1;
      idx_d   = idx_q + BitIdxW'(1);
    end else if (cmd_i.stuff_take) begin
      tone_d = ~tone_q;
      ones_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= '0;
      idx_q   <= '0;
      flag_q  <= 1'b0;
      tone_q  <= 1'b0;
      ones_q  <= '0;
    end else begin
      shift_q <= shift_d;
      idx_q   <= idx_d;
      flag_q  <= flag_d;
      tone_q  <= tone_d;
      ones_q  <= ones_d;
    end
  end

endmodule

// ----- hw/rtl/hnbs_ctrl.sv -----
// ----------------------------------------------------------------------------
// hnbs_ctrl
// Controller: sequences load, data symbols and stuffing symbols.
// ----------------------------------------------------------------------------
module hnbs_ctrl import hnbs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DATA;
        end
      end
      ST_DATA: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.data_take = 1'b1;
          if (status_i.stuff_req) begin
            state_d = ST_STUFF;
          end else if (status_i.last_bit) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_STUFF: begin
        out_valid_o    = 1'b1;
        cmd_o.in_stuff = 1'b1;
        if (out_ready_i) begin
          cmd_o.stuff_take = 1'b1;
          state_d = status_i.stuff_last ? ST_IDLE : ST_DATA;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/hdlc_nrzi_bit_stuffing_serializer.sv -----
// ----------------------------------------------------------------------------
// hdlc_nrzi_bit_stuffing_serializer
// First symbol: valid in the cycle after a byte is accepted.
// Throughput: a byte is loaded, then sent as 8 to 10 symbols at one per cycle
// while out_ready_i is high; no new byte is taken until the last symbol is sent.
// Reset: asynchronous, active low; tone state clears to zero, run count clears.
// ----------------------------------------------------------------------------
module hdlc_nrzi_bit_stuffing_serializer import hnbs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ByteW-1:0] byte_in_i,
  input  logic             is_flag_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             tone_sel_o,
  output logic             stuffed_o,
  output logic             last_o
);

  cmd_t    cmd;
  status_t status;

  hnbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  hnbs_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .byte_in_i  (byte_in_i),
    .is_flag_i  (is_flag_i),
    .status_o   (status),
    .tone_sel_o (tone_sel_o),
    .stuffed_o  (stuffed_o),
    .last_o     (last_o)
  );

endmodule
